FILE: hw/rtl/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Codes, constants and result types shared by the I2C register transfer
// sequencer modules.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

	// request commands
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_EVENT = 2'd2;
	localparam logic [1:0] CMD_ERROR = 2'd3;

	// event flag bits
	localparam int EV_START_SENT = 0;
	localparam int EV_ADDR_SENT  = 1;
	localparam int EV_BYTE_DONE  = 2;
	localparam int EV_RX_READY   = 3;
	localparam int EV_TX_EMPTY   = 4;

	// error flag bits
	localparam int ERR_ACK_FAIL = 0;
	localparam int ERR_ARB_LOST = 1;
	localparam int ERR_BUS      = 2;

	// pending condition bits
	localparam int PEND_START = 0;
	localparam int PEND_STOP  = 1;

	// byte kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ADDR = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	// bus conditions
	localparam logic [1:0] COND_NONE  = 2'd0;
	localparam logic [1:0] COND_START = 2'd1;
	localparam logic [1:0] COND_STOP  = 2'd2;

	// control actions
	localparam logic [1:0] CTL_KEEP = 2'd0;
	localparam logic [1:0] CTL_ON   = 2'd1;
	localparam logic [1:0] CTL_OFF  = 2'd2;

	localparam logic [7:0] NO_REGISTER = 8'hFF;
	localparam logic [9:0] POS_REG     = 10'h3FF;

	typedef struct packed {
		logic [1:0] byte_kind;
		logic [7:0] byte_out;
		logic [1:0] bus_condition;
		logic [1:0] ack_control;
		logic [1:0] pos_control;
		logic [1:0] buffer_irq_control;
		logic [1:0] event_irq_control;
		logic       store_valid;
		logic [7:0] buffer_index;
		logic [7:0] store_byte;
		logic       busy_res;
		logic       last;
	} res_t;

	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} pair_t;

endpackage

FILE: hw/rtl/i2cseq_job_if.sv
// ----------------------------------------------------------------------------
// i2cseq_job_if
// Request channel: job starts, engine events and engine errors.
// ----------------------------------------------------------------------------
interface i2cseq_job_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [6:0] device_address;
	logic [7:0] register_number;
	logic [7:0] byte_count;
	logic [4:0] event_flags;
	logic [2:0] error_flags;
	logic [1:0] condition_pending;
	logic [7:0] received_byte;
	logic [7:0] received_byte_next;
	logic [7:0] transmit_byte;

	modport source (
		output valid, command, device_address, register_number, byte_count,
			event_flags, error_flags, condition_pending, received_byte,
			received_byte_next, transmit_byte,
		input  ready
	);
	modport sink (
		input  valid, command, device_address, register_number, byte_count,
			event_flags, error_flags, condition_pending, received_byte,
			received_byte_next, transmit_byte,
		output ready
	);
endinterface

FILE: hw/rtl/i2cseq_res_if.sv
// ----------------------------------------------------------------------------
// i2cseq_res_if
// Result channel: bytes, bus conditions, controls and buffer stores.
// ----------------------------------------------------------------------------
interface i2cseq_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] byte_kind;
	logic [7:0] byte_out;
	logic [1:0] bus_condition;
	logic [1:0] ack_control;
	logic [1:0] pos_control;
	logic [1:0] buffer_irq_control;
	logic [1:0] event_irq_control;
	logic       store_valid;
	logic [7:0] buffer_index;
	logic [7:0] store_byte;
	logic       busy_res;
	logic       last;

	modport source (
		output valid, byte_kind, byte_out, bus_condition, ack_control, pos_control,
			buffer_irq_control, event_irq_control, store_valid, buffer_index,
			store_byte, busy_res, last,
		input  ready
	);
	modport sink (
		input  valid, byte_kind, byte_out, bus_condition, ack_control, pos_control,
			buffer_irq_control, event_irq_control, store_valid, buffer_index,
			store_byte, busy_res, last,
		output ready
	);
endinterface

FILE: hw/rtl/i2cseq_step.sv
// ----------------------------------------------------------------------------
// i2cseq_step
// Input register, transfer state and the single-pass step logic that turns
// one request into one or two results.
// ----------------------------------------------------------------------------
module i2cseq_step import i2cseq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	i2cseq_job_if.sink  job,
	output pair_t       pair,
	output logic        pair_valid,
	input  logic        pair_ready
);

	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [6:0] dev_s1;
	logic [7:0] reg_s1;
	logic [7:0] cnt_s1;
	logic [4:0] ev_s1;
	logic [2:0] err_s1;
	logic [1:0] pend_s1;
	logic [7:0] rx0_s1;
	logic [7:0] rx1_s1;
	logic [7:0] tx_s1;

	logic [7:0] target_q;
	logic [7:0] sub_q;
	logic [7:0] len_q;
	logic [9:0] bp_q;
	logic       reading_q;
	logic       rpd_q;
	logic       busy_q;
	logic       irq_on_q;

	logic [7:0] target_n;
	logic [7:0] sub_n;
	logic [7:0] len_n;
	logic [9:0] bp_n;
	logic       reading_n;
	logic       rpd_n;
	logic       busy_n;
	logic       irq_on_n;

	res_t       r0;
	res_t       r1;
	logic       two;
	logic       rd;
	logic [9:0] len_ext;
	logic [9:0] bp_p1;
	logic [9:0] bp_p2;
	logic [9:0] bp_p3;
	logic       fire;

	assign fire       = valid_s1 && pair_ready;
	assign job.ready  = !valid_s1 || pair_ready;
	assign pair_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (job.valid && job.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job.valid && job.ready) begin
			cmd_s1  <= job.command;
			dev_s1  <= job.device_address;
			reg_s1  <= job.register_number;
			cnt_s1  <= job.byte_count;
			ev_s1   <= job.event_flags;
			err_s1  <= job.error_flags;
			pend_s1 <= job.condition_pending;
			rx0_s1  <= job.received_byte;
			rx1_s1  <= job.received_byte_next;
			tx_s1   <= job.transmit_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			sub_q     <= '0;
			len_q     <= '0;
			bp_q      <= '0;
			reading_q <= 1'b0;
			rpd_q     <= 1'b0;
			busy_q    <= 1'b0;
			irq_on_q  <= 1'b0;
		end else if (fire) begin
			target_q  <= target_n;
			sub_q     <= sub_n;
			len_q     <= len_n;
			bp_q      <= bp_n;
			reading_q <= reading_n;
			rpd_q     <= rpd_n;
			busy_q    <= busy_n;
			irq_on_q  <= irq_on_n;
		end
	end

	assign len_ext = {2'b00, len_q};
	assign bp_p1   = bp_q + 10'd1;
	assign bp_p2   = bp_q + 10'd2;
	assign bp_p3   = bp_q + 10'd3;
	assign rd      = reading_q && rpd_q;

	always_comb begin
		r0        = '0;
		r1        = '0;
		two       = 1'b0;
		target_n  = target_q;
		sub_n     = sub_q;
		len_n     = len_q;
		bp_n      = bp_q;
		reading_n = reading_q;
		rpd_n     = rpd_q;
		busy_n    = busy_q;
		irq_on_n  = irq_on_q;
		r0.buffer_index = bp_q[7:0];

		case (cmd_s1)
			CMD_READ, CMD_WRITE: begin
				target_n  = {dev_s1, 1'b0};
				sub_n     = reg_s1;
				len_n     = cnt_s1;
				bp_n      = '0;
				reading_n = (cmd_s1 == CMD_READ);
				busy_n    = 1'b1;
				rpd_n     = (reg_s1 == NO_REGISTER);
				r0.buffer_index = '0;
				// leave a running transfer's interrupts alone
				if (!irq_on_q) begin
					if (!pend_s1[PEND_START])
						r0.bus_condition = COND_START;
					r0.event_irq_control = CTL_ON;
					irq_on_n = 1'b1;
				end
			end
			CMD_ERROR: begin
				if (err_s1 != '0) begin
					r0.buffer_irq_control = CTL_OFF;
					if (!err_s1[ERR_ARB_LOST] && !pend_s1[PEND_STOP]) begin
						r0.bus_condition     = COND_STOP;
						r0.event_irq_control = CTL_OFF;
						irq_on_n = 1'b0;
					end
				end
				busy_n = 1'b0;
			end
			default: begin
				if (ev_s1[EV_START_SENT]) begin
					r0.pos_control = CTL_OFF;
					r0.ack_control = CTL_ON;
					r0.byte_kind   = KIND_ADDR;
					bp_n = '0;
					if (reading_q && (rpd_q || sub_q == NO_REGISTER)) begin
						rpd_n = 1'b1;
						if (len_q == 8'd2)
							r0.pos_control = CTL_ON;
						r0.byte_out = target_q | 8'h01;
					end else begin
						r0.byte_out = target_q & 8'hFE;
						// mark the register byte as next to send
						if (!rpd_q)
							bp_n = POS_REG;
					end
				end else if (ev_s1[EV_ADDR_SENT]) begin
					if (rd) begin
						if (len_q == 8'd1) begin
							r0.ack_control        = CTL_OFF;
							r0.bus_condition      = COND_STOP;
							r0.buffer_irq_control = CTL_ON;
						end else if (len_q == 8'd2) begin
							r0.ack_control        = CTL_OFF;
							r0.buffer_irq_control = CTL_OFF;
						end else if (len_q == 8'd3) begin
							r0.buffer_irq_control = CTL_OFF;
						end else begin
							r0.buffer_irq_control = CTL_ON;
						end
					end else begin
						r0.buffer_irq_control = CTL_ON;
					end
				end else if (ev_s1[EV_BYTE_DONE]) begin
					if (rd) begin
						r0.bus_condition = COND_STOP;
						if (len_q > 8'd2) begin
							r0.ack_control        = CTL_OFF;
							r0.buffer_irq_control = CTL_ON;
						end
						r0.store_valid  = 1'b1;
						r0.buffer_index = bp_q[7:0];
						r0.store_byte   = rx0_s1;
						r1.store_valid  = 1'b1;
						r1.buffer_index = bp_p1[7:0];
						r1.store_byte   = rx1_s1;
						bp_n = (len_q <= 8'd2) ? bp_p3 : bp_p2;
						two  = 1'b1;
					end else if (rpd_q || !reading_q) begin
						r0.bus_condition = COND_STOP;
						bp_n = bp_p1;
					end else begin
						// register phase over: restart for the read
						r0.bus_condition = COND_START;
						rpd_n = 1'b1;
					end
				end else if (ev_s1[EV_RX_READY]) begin
					r0.store_valid  = 1'b1;
					r0.buffer_index = bp_q[7:0];
					r0.store_byte   = rx0_s1;
					if (len_ext == bp_p1 + 10'd3)
						r0.buffer_irq_control = CTL_OFF;
					bp_n = (len_ext == bp_p1) ? bp_p2 : bp_p1;
				end else if (ev_s1[EV_TX_EMPTY]) begin
					r0.byte_kind = KIND_DATA;
					bp_n = bp_p1;
					if (bp_q != POS_REG) begin
						r0.byte_out = tx_s1;
						if (len_ext == bp_p1)
							r0.buffer_irq_control = CTL_OFF;
					end else begin
						r0.byte_out = sub_q;
						if (reading_q || len_q == 8'd0)
							r0.buffer_irq_control = CTL_OFF;
					end
				end
				// transfer complete
				if (bp_n == len_ext + 10'd1) begin
					rpd_n = 1'b0;
					r0.event_irq_control = CTL_OFF;
					irq_on_n = 1'b0;
					busy_n   = 1'b0;
				end
			end
		endcase

		r0.busy_res = busy_n;
		r1.busy_res = busy_n;
		r0.last     = !two;
		r1.last     = 1'b1;
	end

	assign pair.r0  = r0;
	assign pair.r1  = r1;
	assign pair.two = two;

endmodule

FILE: hw/rtl/i2cseq_obuf.sv
// ----------------------------------------------------------------------------
// i2cseq_obuf
// Result register: holds the results of one request and hands them out one
// per cycle while result.ready is high.
// ----------------------------------------------------------------------------
module i2cseq_obuf import i2cseq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  pair_t         pair,
	input  logic          pair_valid,
	output logic          pair_ready,
	i2cseq_res_if.source  result
);

	pair_t pair_q;
	logic  full_q;
	logic  phase_q;
	res_t  cur;
	logic  take;

	assign take       = full_q && result.ready;
	assign pair_ready = !full_q || (result.ready && (phase_q || !pair_q.two));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (pair_valid && pair_ready) begin
			full_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (take) begin
			// advance to the second result, else drop the entry
			if (!phase_q && pair_q.two)
				phase_q <= 1'b1;
			else
				full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_valid && pair_ready)
			pair_q <= pair;
	end

	assign cur = phase_q ? pair_q.r1 : pair_q.r0;

	assign result.valid              = full_q;
	assign result.byte_kind          = cur.byte_kind;
	assign result.byte_out           = cur.byte_out;
	assign result.bus_condition      = cur.bus_condition;
	assign result.ack_control        = cur.ack_control;
	assign result.pos_control        = cur.pos_control;
	assign result.buffer_irq_control = cur.buffer_irq_control;
	assign result.event_irq_control  = cur.event_irq_control;
	assign result.store_valid        = cur.store_valid;
	assign result.buffer_index       = cur.buffer_index;
	assign result.store_byte         = cur.store_byte;
	assign result.busy_res           = cur.busy_res;
	assign result.last               = cur.last;

endmodule

FILE: hw/rtl/i2c_register_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer
// I2C master register read/write sequencer driven by job and engine requests.
// A request is held in the step's input register and its results then in the
// result register; the first result is valid once it is in the result register.
// Throughput: one request per cycle unless result.ready stalls; a byte-finished
// read gives two results and holds the result register until both are taken.
// Reset: arst_n clears all transfer state and empties both pipeline registers.
// ----------------------------------------------------------------------------
module i2c_register_transfer_sequencer import i2cseq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	i2cseq_job_if.sink    job,
	i2cseq_res_if.source  result
);

	pair_t pair;
	logic  pair_valid;
	logic  pair_ready;

	i2cseq_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job),
		.pair       (pair),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready)
	);

	i2cseq_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.result     (result)
	);

endmodule
